>>> src/frf_pkg.sv
// ----------------------------------------------------------------------------
// frf_pkg
// Shared types and constants for the frame rotate / flip core.
// ----------------------------------------------------------------------------
package frf_pkg;

	localparam int MaxDim     = 256;
	localparam int DimW       = $clog2(MaxDim + 1);
	localparam int CoordW     = $clog2(MaxDim);
	localparam int AddrW      = 2 * CoordW;
	localparam int StoreDepth = MaxDim * MaxDim;
	localparam int TotalW     = AddrW + 1;
	localparam int PixelW     = 32;
	localparam int ModeW      = 2;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = DimW;

	typedef enum logic [ModeW-1:0] {
		MODE_ROT_CW  = 2'd0,
		MODE_ROT_CCW = 2'd1,
		MODE_MIR_H   = 2'd2,
		MODE_MIR_V   = 2'd3
	} mode_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	localparam logic [CfgIdxW-1:0] CFG_SRC_WIDTH  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_SRC_HEIGHT = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MODE       = 2'd2;

	// Out-of-range dimensions act as the nearest legal one.
	function automatic logic [DimW-1:0] clamp_dim(input logic [CfgDataW-1:0] v);
		logic [DimW-1:0] r;
		if (v == '0)
			r = DimW'(1);
		else if (v > CfgDataW'(MaxDim))
			r = DimW'(MaxDim);
		else
			r = DimW'(v);
		return r;
	endfunction

endpackage

>>> src/frf_ram.sv
// ----------------------------------------------------------------------------
// frf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module frf_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/frame_rotate_flip_core.sv
// ----------------------------------------------------------------------------
// frame_rotate_flip_core
// Rotates or mirrors a frame of 32-bit RGBA pixels held in a frame store.
// ----------------------------------------------------------------------------
// A load transaction writes the next source pixel in raster order; loads can
// follow each other every clock unless a read is in flight or a result waits
// on a stalled output. A read transaction returns the next destination pixel:
// the address is formed and presented to the frame store in the accept cycle,
// and the store's registered read data moves into the output register once
// that register is free. Only one read is in flight at a time, so a new read
// waits until the last one has reached the output register. The frame store
// is not cleared; a pixel must be loaded before it is read. Configuration
// writes take effect at the next clock edge.
module frame_rotate_flip_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              opcode,
	input  logic [frf_pkg::PixelW-1:0]        pixel_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [frf_pkg::PixelW-1:0]        pixel_out,
	output logic                              frame_last,
	input  logic                              cfg_we,
	input  logic [frf_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [frf_pkg::CfgDataW-1:0]      cfg_wdata
);

	logic [frf_pkg::DimW-1:0]   width_q;
	logic [frf_pkg::DimW-1:0]   height_q;
	frf_pkg::mode_t             mode_q;

	logic [frf_pkg::AddrW-1:0]  wr_idx_q;
	logic [frf_pkg::CoordW-1:0] col_q;
	logic [frf_pkg::CoordW-1:0] row_q;

	logic                       rd_pend_s1;
	logic                       last_s1;
	logic                       out_valid_q;
	logic [frf_pkg::PixelW-1:0] pixel_out_q;
	logic                       frame_last_q;

	logic                       accept;
	logic                       acc_load;
	logic                       acc_read;
	logic [frf_pkg::TotalW-1:0] total;
	logic [frf_pkg::AddrW-1:0]  wr_idx;
	logic [frf_pkg::TotalW-1:0] wr_idx_inc;
	logic [frf_pkg::DimW-1:0]   dst_w;
	logic [frf_pkg::DimW-1:0]   dst_h;
	logic [frf_pkg::CoordW-1:0] x;
	logic [frf_pkg::CoordW-1:0] y;
	logic [frf_pkg::DimW-1:0]   x_inc;
	logic [frf_pkg::DimW-1:0]   y_inc;
	logic [frf_pkg::CoordW-1:0] sx;
	logic [frf_pkg::CoordW-1:0] sy;
	logic [frf_pkg::TotalW-1:0] rd_addr_full;
	logic [frf_pkg::AddrW-1:0]  rd_addr;
	logic                       rd_last;
	logic [frf_pkg::PixelW-1:0] ram_rdata;

	assign accept   = in_valid && !in_stall;
	assign acc_load = accept && (frf_pkg::opcode_t'(opcode) == frf_pkg::OP_LOAD);
	assign acc_read = accept && (frf_pkg::opcode_t'(opcode) == frf_pkg::OP_READ);

	// Hold off while a read is in flight or the output is blocked.
	assign in_stall = rd_pend_s1 || (out_valid_q && out_stall);

	// Configuration registers, clamped on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= frf_pkg::DimW'(1);
			height_q <= frf_pkg::DimW'(1);
			mode_q   <= frf_pkg::MODE_ROT_CW;
		end else if (cfg_we) begin
			unique case (cfg_index)
				frf_pkg::CFG_SRC_WIDTH:  width_q  <= frf_pkg::clamp_dim(cfg_wdata);
				frf_pkg::CFG_SRC_HEIGHT: height_q <= frf_pkg::clamp_dim(cfg_wdata);
				frf_pkg::CFG_MODE:       mode_q   <= frf_pkg::mode_t'(cfg_wdata[frf_pkg::ModeW-1:0]);
				default: ;
			endcase
		end
	end

	// Write side: restart the index when it falls outside the current frame.
	always_comb begin
		total      = frf_pkg::TotalW'(width_q) * frf_pkg::TotalW'(height_q);
		wr_idx     = ({1'b0, wr_idx_q} >= total) ? '0 : wr_idx_q;
		wr_idx_inc = {1'b0, wr_idx} + frf_pkg::TotalW'(1);
	end

	// Read side: destination geometry, position and source address.
	always_comb begin
		if (mode_q == frf_pkg::MODE_ROT_CW || mode_q == frf_pkg::MODE_ROT_CCW) begin
			dst_w = height_q;
			dst_h = width_q;
		end else begin
			dst_w = width_q;
			dst_h = height_q;
		end

		if ({1'b0, col_q} >= dst_w || {1'b0, row_q} >= dst_h) begin
			x = '0;
			y = '0;
		end else begin
			x = col_q;
			y = row_q;
		end
		x_inc = {1'b0, x} + frf_pkg::DimW'(1);
		y_inc = {1'b0, y} + frf_pkg::DimW'(1);

		unique case (mode_q)
			frf_pkg::MODE_ROT_CW: begin
				sx = y;
				sy = frf_pkg::CoordW'(height_q - x_inc);
			end
			frf_pkg::MODE_ROT_CCW: begin
				sx = frf_pkg::CoordW'(width_q - y_inc);
				sy = x;
			end
			frf_pkg::MODE_MIR_H: begin
				sx = frf_pkg::CoordW'(width_q - x_inc);
				sy = y;
			end
			default: begin
				sx = x;
				sy = frf_pkg::CoordW'(height_q - y_inc);
			end
		endcase

		rd_addr_full = frf_pkg::TotalW'(sy) * frf_pkg::TotalW'(width_q)
			+ frf_pkg::TotalW'(sx);
		rd_addr      = rd_addr_full[frf_pkg::AddrW-1:0];
		rd_last      = (x_inc == dst_w) && (y_inc == dst_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (acc_load)
				wr_idx_q <= (wr_idx_inc >= total) ? '0 : wr_idx_inc[frf_pkg::AddrW-1:0];
			if (acc_read) begin
				if (x_inc < dst_w) begin
					col_q <= x_inc[frf_pkg::CoordW-1:0];
					row_q <= y;
				end else begin
					col_q <= '0;
					row_q <= (y_inc < dst_h) ? y_inc[frf_pkg::CoordW-1:0] : '0;
				end
			end
		end
	end

	frf_ram #(
		.Width (frf_pkg::PixelW),
		.Depth (frf_pkg::StoreDepth)
	) u_store (
		.clk   (clk),
		.we    (acc_load),
		.waddr (wr_idx),
		.wdata (pixel_in),
		.re    (acc_read),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
		end else begin
			priority if (acc_read)
				rd_pend_s1 <= 1'b1;
			else if (rd_pend_s1 && (!out_valid_q || !out_stall))
				rd_pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_read)
			last_s1 <= rd_last;
	end

	// Output register: advance the read data once the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			priority if (rd_pend_s1 && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1 && (!out_valid_q || !out_stall)) begin
			pixel_out_q  <= ram_rdata;
			frame_last_q <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_out_q;
	assign frame_last = frame_last_q;

	a_read_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		acc_read |=> rd_pend_s1)
		else $error("accepted read did not enter the read stage");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_pend_s1 && !out_valid_q) |=> (out_valid && !rd_pend_s1))
		else $error("read data did not move into a free output register");

	a_wr_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_load && !cfg_we) |=> ({1'b0, wr_idx_q} < total))
		else $error("write index left the frame after a load");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_rotate_flip_core. A driver streams load and
// read transactions from a pending queue in random bursts while a monitor
// stalls the output on its own pattern. Each accepted transaction runs
// through a rotate/mirror predictor. The monitor checks every returned pixel
// and its frame_last flag against the oldest predicted pixel. Frame size and
// mode change between phases while the core is idle.
// ----------------------------------------------------------------------------
module testbench;

	localparam int ItemTarget    = 1700;
	localparam int WatchdogLimit = 1000;

	typedef struct {
		frf_pkg::opcode_t               op;
		logic [frf_pkg::PixelW-1:0]     pix;
	} pixel_txn_t;

	typedef struct {
		logic [frf_pkg::PixelW-1:0]     pix;
		logic                           is_last;
	} dest_pixel_t;

	logic                               clk;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_stall;
	logic                               opcode = 1'b0;
	logic [frf_pkg::PixelW-1:0]         pixel_in = '0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic [frf_pkg::PixelW-1:0]         pixel_out;
	logic                               frame_last;
	logic                               cfg_we = 1'b0;
	logic [frf_pkg::CfgIdxW-1:0]        cfg_index = '0;
	logic [frf_pkg::CfgDataW-1:0]       cfg_wdata = '0;

	// Register copies, changed only while the core is idle.
	logic [frf_pkg::CfgDataW-1:0]       cfg_w = 9'd1;
	logic [frf_pkg::CfgDataW-1:0]       cfg_h = 9'd1;
	frf_pkg::mode_t                     cfg_mode = frf_pkg::MODE_ROT_CW;

	// Predictor state, advanced on accepted transactions.
	logic [frf_pkg::PixelW-1:0]         src_frame [frf_pkg::StoreDepth];
	int unsigned                        wr_ptr = 0;
	int unsigned                        rd_col = 0;
	int unsigned                        rd_row = 0;

	// Stimulus planning state: tracks which entries will have been loaded.
	bit                                 loaded [frf_pkg::StoreDepth];
	int unsigned                        plan_wr = 0;
	int unsigned                        plan_col = 0;
	int unsigned                        plan_row = 0;
	int                                 queued = 0;

	pixel_txn_t                         pixel_feed_q[$];
	dest_pixel_t                        dest_pixel_q[$];

	int                                 n_errors = 0;
	int                                 burst_left, gap_left;
	int                                 stall_left, stall_style, style_left;
	int                                 idle_cycles = 0;

	frame_rotate_flip_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.pixel_in   (pixel_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_out  (pixel_out),
		.frame_last (frame_last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned eff_dim(logic [frf_pkg::CfgDataW-1:0] v);
		if (v == 0)
			return 1;
		if (v > frf_pkg::MaxDim)
			return frf_pkg::MaxDim;
		return v;
	endfunction

	function automatic int unsigned dest_w();
		return (cfg_mode == frf_pkg::MODE_ROT_CW || cfg_mode == frf_pkg::MODE_ROT_CCW) ?
			eff_dim(cfg_h) : eff_dim(cfg_w);
	endfunction

	function automatic int unsigned dest_h();
		return (cfg_mode == frf_pkg::MODE_ROT_CW || cfg_mode == frf_pkg::MODE_ROT_CCW) ?
			eff_dim(cfg_w) : eff_dim(cfg_h);
	endfunction

	// Raster address of the source pixel feeding destination (x, y).
	function automatic int unsigned source_addr(int unsigned x, int unsigned y);
		int unsigned w, h, sx, sy;
		w = eff_dim(cfg_w);
		h = eff_dim(cfg_h);
		case (cfg_mode)
		frf_pkg::MODE_ROT_CW: begin
			sx = y;
			sy = h - 1 - x;
		end
		frf_pkg::MODE_ROT_CCW: begin
			sx = w - 1 - y;
			sy = x;
		end
		frf_pkg::MODE_MIR_H: begin
			sx = w - 1 - x;
			sy = y;
		end
		default: begin
			sx = x;
			sy = h - 1 - y;
		end
		endcase
		return (sy * w + sx) % frf_pkg::StoreDepth;
	endfunction

	// Restart a counter left outside the current frame.
	function automatic void clip_raster(inout int unsigned idx);
		if (idx >= eff_dim(cfg_w) * eff_dim(cfg_h))
			idx = 0;
	endfunction

	function automatic void clip_dest(inout int unsigned col, inout int unsigned row);
		if (col >= dest_w() || row >= dest_h()) begin
			col = 0;
			row = 0;
		end
	endfunction

	function automatic void advance_dest(inout int unsigned col, inout int unsigned row);
		if (col + 1 < dest_w()) begin
			col++;
		end else begin
			col = 0;
			row = (row + 1 < dest_h()) ? row + 1 : 0;
		end
	endfunction

	task automatic rotate_flip_step(frf_pkg::opcode_t op, logic [frf_pkg::PixelW-1:0] pix);
		dest_pixel_t res;
		if (op == frf_pkg::OP_LOAD) begin
			clip_raster(wr_ptr);
			src_frame[wr_ptr] = pix;
			wr_ptr++;
			clip_raster(wr_ptr);
		end else begin
			clip_dest(rd_col, rd_row);
			res.pix = src_frame[source_addr(rd_col, rd_row)];
			res.is_last = (rd_col == dest_w() - 1) && (rd_row == dest_h() - 1);
			dest_pixel_q.push_back(res);
			advance_dest(rd_col, rd_row);
		end
	endtask

	function automatic logic [frf_pkg::PixelW-1:0] rand_pixel();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		default: return $urandom();
		endcase
	endfunction

	task automatic queue_load(logic [frf_pkg::PixelW-1:0] pix);
		pixel_txn_t t;
		clip_raster(plan_wr);
		loaded[plan_wr] = 1'b1;
		plan_wr++;
		clip_raster(plan_wr);
		t.op = frf_pkg::OP_LOAD;
		t.pix = pix;
		pixel_feed_q.push_back(t);
		queued++;
	endtask

	// Queue a read only if its source pixel has been loaded.
	function automatic bit queue_read();
		pixel_txn_t t;
		clip_dest(plan_col, plan_row);
		if (!loaded[source_addr(plan_col, plan_row)])
			return 1'b0;
		advance_dest(plan_col, plan_row);
		t.op = frf_pkg::OP_READ;
		t.pix = rand_pixel();
		pixel_feed_q.push_back(t);
		queued++;
		return 1'b1;
	endfunction

	// Hold until every transaction is accepted and every result returned.
	task automatic wait_idle();
		@(negedge clk);
		while (pixel_feed_q.size() != 0 || in_valid || dest_pixel_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_reg(logic [frf_pkg::CfgIdxW-1:0] idx,
			logic [frf_pkg::CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
		frf_pkg::CFG_SRC_WIDTH: cfg_w = val;
		frf_pkg::CFG_SRC_HEIGHT: cfg_h = val;
		default: cfg_mode = frf_pkg::mode_t'(val[frf_pkg::ModeW-1:0]);
		endcase
	endtask

	task automatic program_frame(logic [frf_pkg::CfgDataW-1:0] w,
			logic [frf_pkg::CfgDataW-1:0] h, frf_pkg::mode_t m, logic [2:0] which);
		if (which[0])
			set_reg(frf_pkg::CFG_SRC_WIDTH, w);
		if (which[1])
			set_reg(frf_pkg::CFG_SRC_HEIGHT, h);
		if (which[2])
			set_reg(frf_pkg::CFG_MODE, frf_pkg::CfgDataW'(m));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Driver: bursts of transactions with random gaps in between.
	always @(posedge clk or negedge arst_n) begin : drive_proc
		pixel_txn_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				rotate_flip_step(frf_pkg::opcode_t'(opcode), pixel_in);
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pixel_feed_q.size() != 0) begin
					nxt = pixel_feed_q.pop_front();
					in_valid <= 1'b1;
					opcode <= nxt.op;
					pixel_in <= nxt.pix;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check results and stall the output in styles that change over time.
	always @(posedge clk or negedge arst_n) begin : check_proc
		dest_pixel_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			stall_style <= 0;
			style_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (dest_pixel_q.size() == 0) begin
					$error("unexpected result: pixel_out %08h frame_last %0b",
						pixel_out, frame_last);
					n_errors++;
				end else begin
					want = dest_pixel_q.pop_front();
					if (pixel_out !== want.pix) begin
						$error("pixel_out mismatch: expected %08h, actual %08h",
							want.pix, pixel_out);
						n_errors++;
					end
					if (frame_last !== want.is_last) begin
						$error("frame_last mismatch: expected %0b, actual %0b",
							want.is_last, frame_last);
						n_errors++;
					end
				end
			end
			if (style_left == 0) begin
				stall_style <= $urandom_range(0, 2);
				style_left <= $urandom_range(50, 300);
			end else begin
				style_left <= style_left - 1;
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
			end else if (stall_style == 0 || out_stall) begin
				out_stall <= 1'b0;
				stall_left <= (stall_style == 2) ? $urandom_range(0, 2) : $urandom_range(1, 8);
			end else begin
				out_stall <= 1'b1;
				stall_left <= (stall_style == 1) ? $urandom_range(0, 2) : $urandom_range(0, 9);
			end
		end
	end

	// End the run after too long without any transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WatchdogLimit) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [frf_pkg::CfgDataW-1:0] w, h;
		logic [2:0] which;
		frf_pkg::mode_t m;
		int n, brk, sel;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset frame is a single pixel.
		queue_load('1);
		void'(queue_read());
		wait_idle();

		// Small 3x2 frame read back in every mode.
		program_frame(9'd3, 9'd2, frf_pkg::MODE_ROT_CW, 3'b111);
		queue_load(32'h0000_0000);
		queue_load(32'hFFFF_FFFF);
		queue_load(32'h1234_5678);
		queue_load(32'h8000_0001);
		queue_load(32'hA5A5_A5A5);
		queue_load(32'h5A5A_5A5A);
		repeat (3) void'(queue_read());
		wait_idle();
		program_frame('0, '0, frf_pkg::MODE_ROT_CCW, 3'b100);
		repeat (3) void'(queue_read());
		wait_idle();
		program_frame('0, '0, frf_pkg::MODE_MIR_H, 3'b100);
		repeat (3) void'(queue_read());
		wait_idle();
		program_frame('0, '0, frf_pkg::MODE_MIR_V, 3'b100);
		repeat (2) void'(queue_read());
		repeat (4) queue_load(rand_pixel());
		wait_idle();

		// Zero width acts as one; both counters now lie outside the frame.
		program_frame('0, '0, frf_pkg::MODE_MIR_V, 3'b001);
		queue_load(rand_pixel());
		void'(queue_read());

		for (int phase = 0; queued < ItemTarget; phase++) begin
			m = frf_pkg::mode_t'($urandom_range(0, 3));
			which = {$urandom_range(0, 2) != 0, $urandom_range(0, 2) != 0,
				$urandom_range(0, 2) != 0};
			if (phase < 2 || $urandom_range(0, 24) == 0) begin
				// One dimension at or beyond the maximum, the other minimal.
				sel = $urandom_range(0, 2);
				w = (sel == 0) ? 9'd256 : (sel == 1) ? 9'd257 : 9'd511;
				h = 9'($urandom_range(0, 1));
				if (phase == 1 || $urandom_range(0, 1) == 1) begin
					h = w;
					w = 9'($urandom_range(0, 1));
				end
				which = 3'b111;
			end else begin
				w = ($urandom_range(0, 15) == 0) ? 9'd0 : 9'($urandom_range(1, 12));
				h = ($urandom_range(0, 15) == 0) ? 9'd0 : 9'($urandom_range(1, 12));
				if (eff_dim(which[0] ? w : cfg_w) * eff_dim(which[1] ? h : cfg_h)
						> frf_pkg::MaxDim)
					which[1:0] = 2'b11;
			end
			wait_idle();
			program_frame(w, h, m, which);
			n = 2 * eff_dim(cfg_w) * eff_dim(cfg_h) + $urandom_range(0, 6);
			brk = ($urandom_range(0, 3) == 0) ? n / 2 : -1;
			for (int i = 0; i < n; i++) begin
				// Pause the sender until the core has drained.
				if (i == brk)
					wait_idle();
				if ($urandom_range(0, 1) == 1) begin
					if (!queue_read())
						queue_load(rand_pixel());
				end else begin
					queue_load(rand_pixel());
				end
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
